// ===== rtl/core/atg_pkg.sv =====
package atg_pkg;

   localparam int BUFFER_LENGTH = 65536;
   localparam int BUF_W = $clog2(BUFFER_LENGTH + 1);

   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int SINE_ADDR_W = $clog2(SINE_TABLE_DEPTH);
   localparam int TAB_AW = SINE_ADDR_W + 1;

   localparam logic signed [31:0] BLACKMAN_A0 = 32'sd13763;
   localparam logic signed [31:0] BLACKMAN_A2 = 32'sd2621;
   localparam logic signed [31:0] BLACKMAN_BIAS = BLACKMAN_A0 * 32'sd32768;

   typedef enum logic [2:0] {
      MODE_SILENT         = 3'd0,
      MODE_CLICK          = 3'd1,
      MODE_RECT_TONE      = 3'd2,
      MODE_BLACKMAN_TONE  = 3'd3,
      MODE_RAMPED_TONE    = 3'd4,
      MODE_CONTINUOUS     = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      CSR_MODE         = 3'd0,
      CSR_TONE_STEP    = 3'd1,
      CSR_TONE_PHASE0  = 3'd2,
      CSR_START_SAMPLE = 3'd3,
      CSR_LENGTH       = 3'd4,
      CSR_RAMP         = 3'd5,
      CSR_AMPLITUDE    = 3'd6,
      CSR_WINDOW_STEP  = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_RECT,
      KIND_BLACKMAN,
      KIND_RAMP,
      KIND_CLICK
   } win_kind_type;

   typedef struct packed {
      logic         act;
      win_kind_type kind;
      logic [15:0]  rel_pos;
   } region_type;

   typedef struct packed {
      logic [16:0] w;
      logic [15:0] mag;
      logic        neg;
   } win_out_type;

   typedef logic [14:0] sine_tab_type [SINE_TABLE_DEPTH + 1];

   function automatic logic [14:0] sine_entry(int unsigned k);
      logic [63:0] one;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] r;
      logic [63:0] s;
      logic [63:0] q;
      one = 64'd1 << 30;
      x = (64'(k) * 64'd1686629713) / 64'(SINE_TABLE_DEPTH);
      x2 = (x * x) >> 30;
      r = one;
      r = one - ((x2 * r) >> 30) / 64'd156;
      r = one - ((x2 * r) >> 30) / 64'd110;
      r = one - ((x2 * r) >> 30) / 64'd72;
      r = one - ((x2 * r) >> 30) / 64'd42;
      r = one - ((x2 * r) >> 30) / 64'd20;
      r = one - ((x2 * r) >> 30) / 64'd6;
      s = (x * r) >> 30;
      q = (s + 64'd16384) >> 15;
      if (q > 64'd32767) begin
         q = 64'd32767;
      end
      return q[14:0];
   endfunction

   function automatic sine_tab_type build_sine_tab();
      sine_tab_type t;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         t[k] = sine_entry(k);
      end
      return t;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine_tab();

   // Odd quarters read the table backwards.
   function automatic logic [TAB_AW-1:0] sine_addr(logic [31:0] ph);
      logic [TAB_AW-1:0] pos;
      pos = TAB_AW'(ph[29 -: SINE_ADDR_W]);
      return ph[30] ? (TAB_AW'(SINE_TABLE_DEPTH) - pos) : pos;
   endfunction

endpackage

// ===== rtl/core/audio_stimulus_tone_generator_core.sv =====
// Stimulus tone generator: one signed 16-bit sample for each requested index.
// Configuration is written through the csr_ channel (index, 32-bit data); the
// user must write it only while no request transaction is in flight, which the
// block does not enforce; csr_ready is always high. A request transaction
// carries req_sample_index. The response transaction carries rsp_sample and
// rsp_in_window, which is high inside the active region. The datapath is six
// register stages: region decode, the two phase multiplies, the sine table
// read, the window, the amplitude multiply and the output register. One request
// can be accepted in every cycle unless a low rsp_ready stalls the pipeline.
// Every stage holds its contents while the next one is full and stalled, so a
// low rsp_ready only backs up as far as the pipeline is full; req_ready drops
// once all six stages hold data and rsp_ready is low.
// Reset clears all configuration registers to zero (silent mode) and empties
// the pipeline. Outputs are taken in request order.
module audio_stimulus_tone_generator_core
   import atg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [15:0]        req_sample_index,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_sample,
   output logic               rsp_in_window,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   logic [2:0]  mode_ff;
   logic [31:0] tone_step_ff;
   logic [31:0] tone_phase0_ff;
   logic [15:0] start_sample_ff;
   logic [15:0] length_samples_ff;
   logic [15:0] ramp_samples_ff;
   logic [15:0] amplitude_ff;
   logic [31:0] window_step_ff;

   logic [6:1] valid_ff;
   logic [6:1] en;

   region_type  s1_region_in;
   region_type  s1_region_ff;
   logic [15:0] s1_index_ff;

   logic [31:0]  s2_tone_in;
   logic [31:0]  s2_wang_in;
   logic [31:0]  s2_tone_ff;
   logic [31:0]  s2_wang_ff;
   logic         s2_act_ff;
   win_kind_type s2_kind_ff;

   logic [31:0]       phase;
   logic [31:0]       cos1_ph;
   logic [31:0]       cos2_ph;
   logic [14:0]       s3_sin_mag;
   logic [14:0]       s3_cos1_mag;
   logic [14:0]       s3_cos2_mag;
   logic              s3_sin_neg_ff;
   logic              s3_cos1_neg_ff;
   logic              s3_cos2_neg_ff;
   logic              s3_act_ff;
   win_kind_type      s3_kind_ff;

   win_out_type s4_win_in;
   win_out_type s4_win_ff;
   logic        s4_act_ff;

   logic [32:0] s5_aw_in;
   logic [32:0] s5_aw_ff;
   logic [15:0] s5_mag_ff;
   logic        s5_neg_ff;
   logic        s5_act_ff;

   logic signed [15:0] rsp_sample_in;
   logic signed [15:0] rsp_sample_ff;
   logic               rsp_in_window_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0;
         tone_step_ff <= '0;
         tone_phase0_ff <= '0;
         start_sample_ff <= '0;
         length_samples_ff <= '0;
         ramp_samples_ff <= '0;
         amplitude_ff <= '0;
         window_step_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_MODE: mode_ff <= csr_data[2:0];
            CSR_TONE_STEP: tone_step_ff <= csr_data;
            CSR_TONE_PHASE0: tone_phase0_ff <= csr_data;
            CSR_START_SAMPLE: start_sample_ff <= csr_data[15:0];
            CSR_LENGTH: length_samples_ff <= csr_data[15:0];
            CSR_RAMP: ramp_samples_ff <= csr_data[15:0];
            CSR_AMPLITUDE: amplitude_ff <= csr_data[15:0];
            CSR_WINDOW_STEP: window_step_ff <= csr_data;
            default: mode_ff <= mode_ff;
         endcase
      end
   end

   always_comb begin
      en[6] = !valid_ff[6] || rsp_ready;
      for (int k = 5; k >= 1; k--) begin
         en[k] = !valid_ff[k] || en[k + 1];
      end
   end

   assign req_ready = en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[1]) begin
            valid_ff[1] <= req_valid;
         end
         for (int k = 2; k <= 6; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_ff[k - 1];
            end
         end
      end
   end

   atg_region u_region (
      .mode           (mode_ff),
      .tone_step      (tone_step_ff),
      .start_sample   (start_sample_ff),
      .length_samples (length_samples_ff),
      .ramp_samples   (ramp_samples_ff),
      .sample_index   (req_sample_index),
      .region         (s1_region_in)
   );

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_region_ff <= s1_region_in;
         s1_index_ff <= req_sample_index;
      end
   end

   always_comb begin
      s2_tone_in = 32'(tone_step_ff * 48'(s1_index_ff));
      s2_wang_in = 32'(window_step_ff * 48'(s1_region_ff.rel_pos));
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s2_tone_ff <= s2_tone_in;
         s2_wang_ff <= s2_wang_in;
         s2_act_ff <= s1_region_ff.act;
         s2_kind_ff <= s1_region_ff.kind;
      end
   end

   always_comb begin
      phase = tone_phase0_ff + s2_tone_ff;
      cos1_ph = s2_wang_ff + 32'h4000_0000;
      cos2_ph = {s2_wang_ff[30:0], 1'b0} + 32'h4000_0000;
   end

   atg_sine_rom u_rom_sin (
      .clock   (clock),
      .enable  (en[3]),
      .addr    (sine_addr(phase)),
      .rd_data (s3_sin_mag)
   );

   atg_sine_rom u_rom_cos1 (
      .clock   (clock),
      .enable  (en[3]),
      .addr    (sine_addr(cos1_ph)),
      .rd_data (s3_cos1_mag)
   );

   atg_sine_rom u_rom_cos2 (
      .clock   (clock),
      .enable  (en[3]),
      .addr    (sine_addr(cos2_ph)),
      .rd_data (s3_cos2_mag)
   );

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s3_sin_neg_ff <= phase[31];
         s3_cos1_neg_ff <= cos1_ph[31];
         s3_cos2_neg_ff <= cos2_ph[31];
         s3_act_ff <= s2_act_ff;
         s3_kind_ff <= s2_kind_ff;
      end
   end

   atg_window u_window (
      .kind     (s3_kind_ff),
      .sin_mag  (s3_sin_mag),
      .sin_neg  (s3_sin_neg_ff),
      .cos1_mag (s3_cos1_mag),
      .cos1_neg (s3_cos1_neg_ff),
      .cos2_mag (s3_cos2_mag),
      .cos2_neg (s3_cos2_neg_ff),
      .win      (s4_win_in)
   );

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s4_win_ff <= s4_win_in;
         s4_act_ff <= s3_act_ff;
      end
   end

   assign s5_aw_in = 33'(amplitude_ff) * 33'(s4_win_ff.w);

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s5_aw_ff <= s5_aw_in;
         s5_mag_ff <= s4_win_ff.mag;
         s5_neg_ff <= s4_win_ff.neg;
         s5_act_ff <= s4_act_ff;
      end
   end

   atg_scale u_scale (
      .amp_w  (s5_aw_ff),
      .mag    (s5_mag_ff),
      .neg    (s5_neg_ff),
      .act    (s5_act_ff),
      .sample (rsp_sample_in)
   );

   always_ff @(posedge clock) begin
      if (en[6]) begin
         rsp_sample_ff <= rsp_sample_in;
         rsp_in_window_ff <= s5_act_ff;
      end
   end

   assign rsp_valid = valid_ff[6];
   assign rsp_sample = rsp_sample_ff;
   assign rsp_in_window = rsp_in_window_ff;

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("pipeline not empty after reset");

   a_outside_silent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_in_window) |-> (rsp_sample == 16'sd0))
      else $error("nonzero sample outside the active region");

   a_empty_out_ready: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[6] |-> req_ready)
      else $error("request stalled while the output stage is empty");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      ((&valid_ff) && !rsp_ready) |-> !req_ready)
      else $error("request taken while every stage is full and stalled");

endmodule

// ===== rtl/core/atg_sine_rom.sv =====
module atg_sine_rom
   import atg_pkg::*;
(
   input  logic              clock,
   input  logic              enable,
   input  logic [TAB_AW-1:0] addr,
   output logic [14:0]       rd_data
);

   logic [14:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         rd_data_ff <= SINE_TAB[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/atg_region.sv =====
module atg_region
   import atg_pkg::*;
(
   input  logic [2:0]  mode,
   input  logic [31:0] tone_step,
   input  logic [15:0] start_sample,
   input  logic [15:0] length_samples,
   input  logic [15:0] ramp_samples,
   input  logic [15:0] sample_index,
   output region_type  region
);

   logic [16:0] t1;
   logic [16:0] t2;
   logic [17:0] t3;
   logic        in_buf;
   logic        ge_start;
   logic        no_tone;
   logic [15:0] d_rise;
   logic [15:0] d_fall;

   always_comb begin
      t1 = 17'(start_sample) + 17'(ramp_samples);
      t2 = 17'(start_sample) + 17'(length_samples);
      t3 = 18'(t2) + 18'(ramp_samples);
      in_buf = BUF_W'(sample_index) < BUF_W'(BUFFER_LENGTH);
      ge_start = sample_index >= start_sample;
      no_tone = (tone_step == '0) || (length_samples == '0);
      d_rise = sample_index - start_sample;
      d_fall = 16'(t3 - 18'(sample_index));
      region.act = 1'b0;
      region.kind = KIND_RECT;
      region.rel_pos = d_rise;
      case (mode_type'(mode))
         MODE_CLICK: begin
            region.kind = KIND_CLICK;
            region.act = sample_index < length_samples;
         end
         MODE_RECT_TONE, MODE_BLACKMAN_TONE: begin
            region.kind = (mode_type'(mode) == MODE_BLACKMAN_TONE) ? KIND_BLACKMAN
                                                                  : KIND_RECT;
            region.act = !no_tone && ge_start && (17'(sample_index) <= t2);
         end
         MODE_RAMPED_TONE: begin
            region.act = !no_tone && ge_start && (18'(sample_index) < t3);
            if (17'(sample_index) < t1) begin
               region.kind = KIND_RAMP;
            end else if (17'(sample_index) > t2) begin
               region.kind = KIND_RAMP;
               region.rel_pos = d_fall;
            end
         end
         MODE_CONTINUOUS: begin
            region.act = tone_step != '0;
         end
         default: begin
            region.act = 1'b0;
         end
      endcase
      region.act = region.act && in_buf;
   end

endmodule

// ===== rtl/core/atg_window.sv =====
module atg_window
   import atg_pkg::*;
(
   input  win_kind_type kind,
   input  logic [14:0]  sin_mag,
   input  logic         sin_neg,
   input  logic [14:0]  cos1_mag,
   input  logic         cos1_neg,
   input  logic [14:0]  cos2_mag,
   input  logic         cos2_neg,
   output win_out_type  win
);

   logic signed [15:0] c1;
   logic signed [15:0] c2;
   logic signed [31:0] w30;
   logic signed [31:0] wsum;
   logic [16:0]        w_blk;
   logic signed [17:0] rsum;
   logic [16:0]        w_ramp;

   always_comb begin
      c1 = cos1_neg ? -$signed({1'b0, cos1_mag}) : $signed({1'b0, cos1_mag});
      c2 = cos2_neg ? -$signed({1'b0, cos2_mag}) : $signed({1'b0, cos2_mag});
      w30 = BLACKMAN_BIAS - (32'(c1) <<< 14) + BLACKMAN_A2 * 32'(c2);
      wsum = w30 + 32'sd16384;
      if (w30 < 0) begin
         w_blk = '0;
      end else if ((wsum >>> 15) > 32'sd32768) begin
         w_blk = 17'd32768;
      end else begin
         w_blk = 17'(wsum >>> 15);
      end
      rsum = 18'sd32769 - 18'(c1);
      w_ramp = rsum[17:1];
      win.mag = {1'b0, sin_mag};
      win.neg = sin_neg;
      case (kind)
         KIND_BLACKMAN: win.w = w_blk;
         KIND_RAMP: win.w = w_ramp;
         KIND_CLICK: begin
            win.w = 17'd32767;
            win.mag = 16'd32768;
            win.neg = 1'b0;
         end
         default: win.w = 17'd32768;
      endcase
   end

endmodule

// ===== rtl/core/atg_scale.sv =====
module atg_scale
   import atg_pkg::*;
(
   input  logic [32:0]        amp_w,
   input  logic [15:0]        mag,
   input  logic               neg,
   input  logic               act,
   output logic signed [15:0] sample
);

   logic [48:0] prod;
   logic [49:0] sum;
   logic [19:0] r;
   logic [15:0] val;

   always_comb begin
      prod = 49'(amp_w) * 49'(mag);
      sum = 50'(prod) + (50'd1 << 29);
      r = sum[49:30];
      if (neg) begin
         val = (r > 20'd32768) ? 16'h8000 : 16'(20'd0 - r);
      end else begin
         val = (r > 20'd32767) ? 16'h7FFF : r[15:0];
      end
      sample = act ? $signed(val) : 16'sd0;
   end

endmodule

// ===== sim/tb_audio_stimulus_tone_generator_core.sv =====
module tb_audio_stimulus_tone_generator_core;
   import atg_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] MODE_SPARE_A = 3'd6;
   localparam logic [2:0] MODE_SPARE_B = 3'd7;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int PHASES = 28;
   localparam int ITEMS_PER_PHASE = 48;
   localparam longint unsigned ONE_Q30 = 64'd1 << 30;
   localparam longint unsigned TAYLOR_DIV [6] = '{156, 110, 72, 42, 20, 6};

   typedef struct {
      logic [15:0]        idx;
      logic signed [15:0] sample;
      logic               in_window;
   } tone_expect_t;

   typedef enum logic {ROW_REG, ROW_ITEM} row_kind_t;

   typedef struct packed {
      row_kind_t          kind;
      csr_index_type      reg_idx;
      logic [31:0]        value;
      logic               typed;
      logic signed [15:0] sample;
      logic               in_window;
   } stim_row_t;

   localparam stim_row_t OPENING_ROWS [50] = '{
      '{ROW_ITEM, CSR_MODE, 32'd0, 1'b1, 16'sd0, 1'b0},
      '{ROW_REG, CSR_MODE, 32'(MODE_CLICK), 1'b0, 16'sd0, 1'b0},
      '{ROW_REG, CSR_AMPLITUDE, 32'd32768, 1'b0, 16'sd0, 1'b0},
      '{ROW_REG, CSR_LENGTH, 32'd4, 1'b0, 16'sd0, 1'b0},
      '{ROW_ITEM, CSR_MODE, 32'd0, 1'b1, 16'sd32767, 1'b1},
      '{ROW_ITEM, CSR_MODE, 32'd4, 1'b1, 16'sd0, 1'b0},
      '{ROW_REG, CSR_AMPLITUDE, 32'd0, 1'b0, 16'sd0, 1'b0},
      '{ROW_ITEM, CSR_MODE, 32'd1, 1'b1, 16'sd0, 1'b1},
      '{ROW_REG, CSR_MODE, 32'(MODE_SPARE_A), 1'b0, 16'sd0, 1'b0},
      '{ROW_ITEM, CSR_MODE, 32'd2, 1'b1, 16'sd0, 1'b0},
      '{ROW_REG, CSR_MODE, 32'(MODE_SPARE_B), 1'b0, 16'sd0, 1'b0},
      '{ROW_ITEM, CSR_MODE, 32'd2, 1'b1, 16'sd0, 1'b0},
      '{ROW_REG, CSR_MODE, 32'(MODE_CONTINUOUS), 1'b0, 16'sd0, 1'b0},
      '{ROW_ITEM, CSR_MODE, 32'd7, 1'b1, 16'sd0, 1'b0},
      '{ROW_REG, CSR_TONE_STEP, 32'h4000_0000, 1'b0, 16'sd0, 1'b0},
      '{ROW_REG, CSR_AMPLITUDE, 32'd32768, 1'b0, 16'sd0, 1'b0},
      '{ROW_ITEM, CSR_MODE, 32'd0, 1'b1, 16'sd0, 1'b1},
      '{ROW_ITEM, CSR_MODE, 32'd1, 1'b0, 16'sd0, 1'b0},
      '{ROW_ITEM, CSR_MODE, 32'd3, 1'b0, 16'sd0, 1'b0},
      '{ROW_REG, CSR_AMPLITUDE, 32'd65535, 1'b0, 16'sd0, 1'b0},
      '{ROW_ITEM, CSR_MODE, 32'd1, 1'b0, 16'sd0, 1'b0},
      '{ROW_ITEM, CSR_MODE, 32'd3, 1'b0, 16'sd0, 1'b0},
      '{ROW_REG, CSR_TONE_PHASE0, 32'hFFFF_FFFF, 1'b0, 16'sd0, 1'b0},
      '{ROW_ITEM, CSR_MODE, 32'd65535, 1'b0, 16'sd0, 1'b0},
      '{ROW_REG, CSR_MODE, 32'(MODE_RECT_TONE), 1'b0, 16'sd0, 1'b0},
      '{ROW_REG, CSR_START_SAMPLE, 32'd100, 1'b0, 16'sd0, 1'b0},
      '{ROW_REG, CSR_LENGTH, 32'd0, 1'b0, 16'sd0, 1'b0},
      '{ROW_ITEM, CSR_MODE, 32'd100, 1'b1, 16'sd0, 1'b0},
      '{ROW_REG, CSR_LENGTH, 32'd10, 1'b0, 16'sd0, 1'b0},
      '{ROW_REG, CSR_AMPLITUDE, 32'd32768, 1'b0, 16'sd0, 1'b0},
      '{ROW_REG, CSR_TONE_STEP, 32'h0123_4567, 1'b0, 16'sd0, 1'b0},
      '{ROW_ITEM, CSR_MODE, 32'd99, 1'b1, 16'sd0, 1'b0},
      '{ROW_ITEM, CSR_MODE, 32'd100, 1'b0, 16'sd0, 1'b0},
      '{ROW_ITEM, CSR_MODE, 32'd110, 1'b0, 16'sd0, 1'b0},
      '{ROW_ITEM, CSR_MODE, 32'd111, 1'b1, 16'sd0, 1'b0},
      '{ROW_REG, CSR_MODE, 32'(MODE_BLACKMAN_TONE), 1'b0, 16'sd0, 1'b0},
      '{ROW_REG, CSR_WINDOW_STEP, 32'd390451572, 1'b0, 16'sd0, 1'b0},
      '{ROW_ITEM, CSR_MODE, 32'd100, 1'b0, 16'sd0, 1'b0},
      '{ROW_ITEM, CSR_MODE, 32'd110, 1'b0, 16'sd0, 1'b0},
      '{ROW_REG, CSR_MODE, 32'(MODE_RAMPED_TONE), 1'b0, 16'sd0, 1'b0},
      '{ROW_REG, CSR_START_SAMPLE, 32'd50, 1'b0, 16'sd0, 1'b0},
      '{ROW_REG, CSR_LENGTH, 32'd20, 1'b0, 16'sd0, 1'b0},
      '{ROW_REG, CSR_RAMP, 32'd8, 1'b0, 16'sd0, 1'b0},
      '{ROW_REG, CSR_WINDOW_STEP, 32'h1000_0000, 1'b0, 16'sd0, 1'b0},
      '{ROW_ITEM, CSR_MODE, 32'd49, 1'b1, 16'sd0, 1'b0},
      '{ROW_ITEM, CSR_MODE, 32'd50, 1'b0, 16'sd0, 1'b0},
      '{ROW_ITEM, CSR_MODE, 32'd57, 1'b0, 16'sd0, 1'b0},
      '{ROW_ITEM, CSR_MODE, 32'd58, 1'b0, 16'sd0, 1'b0},
      '{ROW_ITEM, CSR_MODE, 32'd71, 1'b0, 16'sd0, 1'b0},
      '{ROW_ITEM, CSR_MODE, 32'd78, 1'b1, 16'sd0, 1'b0}
   };

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [15:0]        req_sample_index;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [15:0] rsp_sample;
   logic               rsp_in_window;
   logic               csr_valid;
   logic               csr_ready;
   csr_index_type      csr_index;
   logic [31:0]        csr_data;

   logic [2:0]  cfg_mode;
   logic [31:0] cfg_tone_step;
   logic [31:0] cfg_phase0;
   logic [15:0] cfg_start;
   logic [15:0] cfg_length;
   logic [15:0] cfg_ramp;
   logic [15:0] cfg_amplitude;
   logic [31:0] cfg_window_step;

   int          sine_q15 [SINE_TABLE_DEPTH + 1];
   tone_expect_t pending_samples [$];
   int          mismatches;
   int          send_idle_pct;
   int          stall_pct;
   int unsigned cycle_count;

   audio_stimulus_tone_generator_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_index (req_sample_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample       (rsp_sample),
      .rsp_in_window    (rsp_in_window),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #6ns clock = ~clock;

   function automatic int taylor_sine_q15(int k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned r;
      longint unsigned s;
      longint unsigned q;
      x = (64'(k) * 64'd1686629713) / 64'(SINE_TABLE_DEPTH);
      x2 = (x * x) >> 30;
      r = ONE_Q30;
      for (int j = 0; j < 6; j++) begin
         r = ONE_Q30 - ((x2 * r) >> 30) / TAYLOR_DIV[j];
      end
      s = (x * r) >> 30;
      q = (s + 64'd16384) >> 15;
      if (q > 64'd32767) begin
         q = 64'd32767;
      end
      return int'(q);
   endfunction

   function automatic int sine_of(logic [31:0] ph);
      longint unsigned pos;
      longint unsigned addr;
      pos = (64'(ph[29:0]) * 64'(SINE_TABLE_DEPTH)) >> 30;
      addr = ph[30] ? 64'(SINE_TABLE_DEPTH) - pos : pos;
      if (addr > 64'(SINE_TABLE_DEPTH)) begin
         addr = 64'(SINE_TABLE_DEPTH);
      end
      return ph[31] ? -sine_q15[addr] : sine_q15[addr];
   endfunction

   function automatic int cosine_of(logic [31:0] ph);
      return sine_of(ph + QUARTER_TURN);
   endfunction

   // Rounds amp * w * s / 2^30 half away from zero and saturates to 16 bits.
   function automatic logic [15:0] scale_q30(longint unsigned amp, longint unsigned w, int s);
      longint unsigned mag;
      longint unsigned r;
      mag = (s < 0) ? 64'(-s) : 64'(s);
      r = (amp * w * mag + (64'd1 << 29)) >> 30;
      if (s < 0) begin
         if (r > 64'd32768) begin
            r = 64'd32768;
         end
         return 16'(64'd65536 - r);
      end
      if (r > 64'd32767) begin
         r = 64'd32767;
      end
      return 16'(r);
   endfunction

   function automatic logic [31:0] blackman_weight(logic [31:0] a);
      longint w30;
      longint w;
      w30 = 64'sd13763 * 64'sd32768 - 64'sd16384 * longint'(cosine_of(a))
            + 64'sd2621 * longint'(cosine_of({a[30:0], 1'b0}));
      if (w30 < 0) begin
         w30 = 0;
      end
      w = (w30 + 64'sd16384) >>> 15;
      if (w > 64'sd32768) begin
         w = 64'sd32768;
      end
      return 32'(w);
   endfunction

   function automatic logic [31:0] raised_cos_weight(logic [31:0] a);
      return 32'((32769 - cosine_of(a)) >>> 1);
   endfunction

   function automatic tone_expect_t tone_sample_for(logic [15:0] idx);
      tone_expect_t res;
      logic [31:0]  ph;
      logic [31:0]  rel;
      logic [31:0]  t1;
      logic [31:0]  t2;
      logic [31:0]  t3;
      logic [31:0]  w;
      logic         act;
      res.idx = idx;
      res.sample = '0;
      res.in_window = 1'b0;
      ph = cfg_phase0 + cfg_tone_step * 32'(idx);
      t1 = 32'(cfg_start) + 32'(cfg_ramp);
      t2 = 32'(cfg_start) + 32'(cfg_length);
      t3 = t2 + 32'(cfg_ramp);
      rel = 32'(idx) - 32'(cfg_start);
      w = 32'd32768;
      act = 1'b0;
      case (cfg_mode)
         MODE_CLICK: begin
            if (idx < cfg_length) begin
               res.sample = scale_q30(64'(cfg_amplitude), 64'd32767, 32768);
               res.in_window = 1'b1;
            end
         end
         MODE_RECT_TONE, MODE_BLACKMAN_TONE: begin
            if (cfg_tone_step != 0 && cfg_length != 0 && idx >= cfg_start
                && 32'(idx) <= t2) begin
               act = 1'b1;
               if (cfg_mode == MODE_BLACKMAN_TONE) begin
                  w = blackman_weight(cfg_window_step * rel);
               end
            end
         end
         MODE_RAMPED_TONE: begin
            if (cfg_tone_step != 0 && cfg_length != 0 && idx >= cfg_start
                && 32'(idx) < t3) begin
               act = 1'b1;
               if (32'(idx) < t1) begin
                  w = raised_cos_weight(cfg_window_step * rel);
               end else if (32'(idx) > t2) begin
                  w = raised_cos_weight(cfg_window_step * (t3 - 32'(idx)));
               end
            end
         end
         MODE_CONTINUOUS: begin
            act = (cfg_tone_step != 0);
         end
         default: begin
            act = 1'b0;
         end
      endcase
      if (act) begin
         res.sample = scale_q30(64'(cfg_amplitude), 64'(w), sine_of(ph));
         res.in_window = 1'b1;
      end
      return res;
   endfunction

   function automatic logic [2:0] pick_mode();
      case ($urandom_range(9))
         0: return MODE_SILENT;
         1: return MODE_CLICK;
         2, 3: return MODE_RECT_TONE;
         4, 5: return MODE_BLACKMAN_TONE;
         6, 7: return MODE_RAMPED_TONE;
         8: return MODE_CONTINUOUS;
         default: return $urandom_range(1) ? MODE_SPARE_A : MODE_SPARE_B;
      endcase
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(19))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2, 3, 4, 5, 6: return 32'($urandom_range(32'h03FF_FFFF));
         default: return 32'($urandom());
      endcase
   endfunction

   function automatic logic [15:0] pick_span(int unsigned typical);
      case ($urandom_range(19))
         0, 1: return 16'd0;
         2: return 16'hFFFF;
         3, 4: return 16'($urandom_range(65535));
         default: return 16'($urandom_range(typical, 1));
      endcase
   endfunction

   function automatic logic [15:0] pick_amplitude();
      case ($urandom_range(19))
         0: return 16'd0;
         1, 2: return 16'd32768;
         3: return 16'($urandom_range(65535, 32769));
         default: return 16'($urandom_range(32768));
      endcase
   endfunction

   function automatic logic [15:0] pick_index();
      longint edges [12];
      longint lo;
      longint hi;
      longint pick;
      edges[0] = longint'(cfg_start) - 1;
      edges[1] = longint'(cfg_start);
      edges[2] = longint'(cfg_start) + longint'(cfg_ramp) - 1;
      edges[3] = longint'(cfg_start) + longint'(cfg_ramp);
      edges[4] = longint'(cfg_start) + longint'(cfg_length);
      edges[5] = edges[4] + 1;
      edges[6] = edges[4] + longint'(cfg_ramp) - 1;
      edges[7] = edges[4] + longint'(cfg_ramp);
      edges[8] = longint'(cfg_length) - 1;
      edges[9] = longint'(cfg_length);
      edges[10] = 0;
      edges[11] = 65535;
      case ($urandom_range(9))
         0, 1: begin
            return 16'($urandom_range(65535));
         end
         2, 3: begin
            pick = edges[$urandom_range(11)];
            if (pick < 0 || pick > 65535) begin
               return 16'($urandom_range(65535));
            end
            return 16'(pick);
         end
         default: begin
            if (cfg_mode == MODE_CLICK) begin
               lo = 0;
               hi = longint'(cfg_length) + 8;
            end else begin
               lo = (cfg_start > 16'd8) ? longint'(cfg_start) - 8 : 0;
               hi = edges[7] + 8;
            end
            if (hi > 65535) begin
               hi = 65535;
            end
            return 16'($urandom_range(32'(hi), 32'(lo)));
         end
      endcase
   endfunction

   task automatic write_reg(input csr_index_type idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_MODE:         cfg_mode = data[2:0];
         CSR_TONE_STEP:    cfg_tone_step = data;
         CSR_TONE_PHASE0:  cfg_phase0 = data;
         CSR_START_SAMPLE: cfg_start = data[15:0];
         CSR_LENGTH:       cfg_length = data[15:0];
         CSR_RAMP:         cfg_ramp = data[15:0];
         CSR_AMPLITUDE:    cfg_amplitude = data[15:0];
         CSR_WINDOW_STEP:  cfg_window_step = data;
         default:          ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Valid stays high between back-to-back transactions and drops only for a gap.
   task automatic send_index(input tone_expect_t want);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_index <= want.idx;
      do @(posedge clock); while (!req_ready);
      pending_samples.push_back(want);
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
      cycle_count <= cycle_count + 1;
   end

   always @(posedge clock) begin : check_responses
      tone_expect_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_samples.size() == 0) begin
            $display("%0t: response with nothing outstanding: sample %0d in_window %0b",
                     $time, rsp_sample, rsp_in_window);
            mismatches++;
         end else begin
            want = pending_samples.pop_front();
            if (rsp_sample !== want.sample) begin
               $display("%0t: index %0d sample: expected %0d, actual %0d",
                        $time, want.idx, want.sample, rsp_sample);
               mismatches++;
            end
            if (rsp_in_window !== want.in_window) begin
               $display("%0t: index %0d in_window: expected %0b, actual %0b",
                        $time, want.idx, want.in_window, rsp_in_window);
               mismatches++;
            end
         end
      end
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb_audio_stimulus_tone_generator_core: done, errors");
      $finish;
   end

   initial begin : main
      stim_row_t    row;
      tone_expect_t want;
      logic [31:0]  win_step;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample_index = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_MODE;
      csr_data = '0;
      cfg_mode = MODE_SILENT;
      cfg_tone_step = '0;
      cfg_phase0 = '0;
      cfg_start = '0;
      cfg_length = '0;
      cfg_ramp = '0;
      cfg_amplitude = '0;
      cfg_window_step = '0;
      mismatches = 0;
      cycle_count = 0;
      send_idle_pct = 23;
      stall_pct = 23;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         sine_q15[k] = taylor_sine_q15(k);
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (OPENING_ROWS[r]) begin
         row = OPENING_ROWS[r];
         if (row.kind == ROW_REG) begin
            drain_pipeline();
            write_reg(row.reg_idx, row.value);
         end else begin
            want = tone_sample_for(row.value[15:0]);
            if (row.typed) begin
               want.sample = row.sample;
               want.in_window = row.in_window;
            end
            send_index(want);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 59; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 59; end
            default: begin send_idle_pct = 23; stall_pct = 23; end
         endcase
         drain_pipeline();
         write_reg(CSR_MODE, 32'(pick_mode()));
         write_reg(CSR_TONE_STEP, pick_word());
         write_reg(CSR_TONE_PHASE0, 32'($urandom()));
         write_reg(CSR_START_SAMPLE, 32'(pick_span(2000)));
         write_reg(CSR_LENGTH, 32'(pick_span(400)));
         write_reg(CSR_RAMP, 32'(pick_span(150)));
         write_reg(CSR_AMPLITUDE, 32'(pick_amplitude()));
         // Most settings use the step that spans the window or one ramp exactly.
         if ($urandom_range(9) < 3) begin
            win_step = pick_word();
         end else if (cfg_mode == MODE_RAMPED_TONE && cfg_ramp != 0) begin
            win_step = 32'((64'd1 << 32) / (64'd2 * 64'(cfg_ramp)));
         end else if (cfg_length != 0) begin
            win_step = 32'((64'd1 << 32) / 64'(cfg_length));
         end else begin
            win_step = pick_word();
         end
         write_reg(CSR_WINDOW_STEP, win_step);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_index(tone_sample_for(pick_index()));
         end
      end

      drain_pipeline();
      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_audio_stimulus_tone_generator_core: done, clean");
      end else begin
         $display("tb_audio_stimulus_tone_generator_core: done, errors");
      end
      $finish;
   end

endmodule
